// ----- rtl/core/ptrc_pkg.sv -----
// shared types, constants and register map of the pixel color and edge tracer
package ptrc_pkg;

    localparam int unsigned FRAME_PIXELS_DEF = 1048576;

    localparam logic [7:0] EDGE_THRESHOLD_RST = 8'd80;
    localparam logic [7:0] ACCUM_STEP_RST     = 8'd16;

    localparam logic [7:0] RED_MIN   = 8'd100;
    localparam logic [7:0] GREEN_MIN = 8'd60;
    localparam logic [7:0] BLUE_MIN  = 8'd100;
    localparam logic [7:0] FULL_ON   = 8'hFF;

    localparam int unsigned APB_AW = 5;
    localparam int unsigned APB_DW = 32;

    typedef enum logic [2:0] {
        REG_TRACE_TARGET   = 3'd0,
        REG_COLOR_SELECT   = 3'd1,
        REG_PATTERN_MODE   = 3'd2,
        REG_EDGE_THRESHOLD = 3'd3,
        REG_ACCUM_STEP     = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        COLOR_RED   = 2'd0,
        COLOR_GREEN = 2'd1,
        COLOR_BLUE  = 2'd2,
        COLOR_NONE  = 2'd3
    } t_color;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic       frame_start;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [7:0] accum_level;
        logic       hit;
    } t_pix_out;

    typedef struct packed {
        logic       trace_target;
        logic [1:0] color_select;
        logic       pattern_mode;
        logic [7:0] edge_threshold;
        logic [7:0] accum_step;
    } t_cfg;

    // word held between the input register and the result register
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] diff_red;
        logic [7:0] diff_green;
        logic [7:0] diff_blue;
        logic       emit;
        logic       access;
        logic       fresh;
    } t_stage;

endpackage

// ----- rtl/core/ptrc_cfg_regs.sv -----
// apb configuration registers
module ptrc_cfg_regs
    import ptrc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign reg_idx = t_reg_idx'(paddr[APB_AW-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trace_target   <= 1'b0;
            r_cfg.color_select   <= COLOR_RED;
            r_cfg.pattern_mode   <= 1'b0;
            r_cfg.edge_threshold <= EDGE_THRESHOLD_RST;
            r_cfg.accum_step     <= ACCUM_STEP_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_TRACE_TARGET:   r_cfg.trace_target   <= pwdata[0];
                REG_COLOR_SELECT:   r_cfg.color_select   <= pwdata[1:0];
                REG_PATTERN_MODE:   r_cfg.pattern_mode   <= pwdata[0];
                REG_EDGE_THRESHOLD: r_cfg.edge_threshold <= pwdata[7:0];
                REG_ACCUM_STEP:     r_cfg.accum_step     <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_TRACE_TARGET:   prdata = {31'd0, r_cfg.trace_target};
            REG_COLOR_SELECT:   prdata = {30'd0, r_cfg.color_select};
            REG_PATTERN_MODE:   prdata = {31'd0, r_cfg.pattern_mode};
            REG_EDGE_THRESHOLD: prdata = {24'd0, r_cfg.edge_threshold};
            REG_ACCUM_STEP:     prdata = {24'd0, r_cfg.accum_step};
            default:            prdata = '0;
        endcase
    end

endmodule

// ----- rtl/core/ptrc_ram.sv -----
// single write, single read port frame store with registered read data
module ptrc_ram #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/ptrc_input_stage.sv -----
// input register, previous pixel, store position and fill count
module ptrc_input_stage
    import ptrc_pkg::*;
#(
    parameter int unsigned FRAME_PIXELS = FRAME_PIXELS_DEF,
    parameter int unsigned AW           = $clog2(FRAME_PIXELS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  t_pix_in       i_in_data,
    input  t_cfg          i_cfg,
    input  logic          i_stage_adv,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    output logic          o_rd_en,
    output logic [AW-1:0] o_rd_addr,
    output logic          o_stage_vld,
    output t_stage        o_stage,
    output logic [AW-1:0] o_stage_idx
);

    logic          r_stage_vld;
    t_stage        r_stage;
    logic [AW-1:0] r_stage_idx;
    logic [7:0]    r_prev_red;
    logic [7:0]    r_prev_green;
    logic [7:0]    r_prev_blue;
    logic [AW-1:0] r_pos;
    logic [AW:0]   r_fill;

    logic          accept;
    logic          access;
    logic [AW-1:0] n_pos;

    assign o_in_stall = r_stage_vld && !i_stage_adv;
    assign accept     = i_in_valid && !o_in_stall;
    assign access     = i_cfg.trace_target && !i_in_data.frame_start;
    assign o_rd_en    = accept && access;
    assign o_rd_addr  = r_pos;

    always_comb begin
        n_pos = r_pos;
        if (i_in_data.frame_start) begin
            n_pos = '0;
        end else if (i_cfg.trace_target) begin
            n_pos = (r_pos == AW'(FRAME_PIXELS - 1)) ? '0 : r_pos + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage_vld  <= 1'b0;
            r_prev_red   <= '0;
            r_prev_green <= '0;
            r_prev_blue  <= '0;
            r_pos        <= '0;
            r_fill       <= '0;
        end else begin
            if (accept) begin
                r_stage_vld  <= 1'b1;
                r_prev_red   <= i_in_data.red_in;
                r_prev_green <= i_in_data.green_in;
                r_prev_blue  <= i_in_data.blue_in;
                r_pos        <= n_pos;
            end else if (i_stage_adv) begin
                r_stage_vld <= 1'b0;
            end
            // entries are written in order from 0, so the written ones form a prefix
            if (i_wr_en && ({1'b0, i_wr_addr} == r_fill)) begin
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_stage.red        <= i_in_data.red_in;
            r_stage.green      <= i_in_data.green_in;
            r_stage.blue       <= i_in_data.blue_in;
            r_stage.diff_red   <= i_in_data.red_in - r_prev_red;
            r_stage.diff_green <= i_in_data.green_in - r_prev_green;
            r_stage.diff_blue  <= i_in_data.blue_in - r_prev_blue;
            r_stage.emit       <= !(i_cfg.trace_target && i_in_data.frame_start);
            r_stage.access     <= access;
            r_stage.fresh      <= ({1'b0, r_pos} >= r_fill);
            r_stage_idx        <= r_pos;
        end
    end

    assign o_stage_vld = r_stage_vld;
    assign o_stage     = r_stage;
    assign o_stage_idx = r_stage_idx;

`ifndef ASSERT_OFF
    a_wr_within_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr_en |-> ({1'b0, i_wr_addr} <= r_fill))
        else $error("store write beyond the written prefix");

    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= (AW+1)'(FRAME_PIXELS))
        else $error("fill count beyond frame size");
`endif

endmodule

// ----- rtl/core/ptrc_result_stage.sv -----
// color tests, edge test, level update and the output register
module ptrc_result_stage
    import ptrc_pkg::*;
#(
    parameter int unsigned FRAME_PIXELS = FRAME_PIXELS_DEF,
    parameter int unsigned AW           = $clog2(FRAME_PIXELS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg          i_cfg,
    input  logic          i_stage_vld,
    input  t_stage        i_stage,
    input  logic [AW-1:0] i_stage_idx,
    input  logic [7:0]    i_rdata,
    output logic          o_stage_adv,
    output logic          o_wr_en,
    output logic [AW-1:0] o_wr_addr,
    output logic [7:0]    o_wr_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output t_pix_out      o_out_data
);

    logic     r_out_vld;
    t_pix_out r_out;

    logic       out_free;
    logic [7:0] old_lvl;
    logic [8:0] sum_lvl;
    logic [7:0] new_lvl;
    logic       is_edge;
    logic       red_pass;
    logic       green_pass;
    logic       blue_pass;
    t_pix_out   n_out;

    assign out_free    = !r_out_vld || !i_out_stall;
    assign o_stage_adv = i_stage_vld && (!i_stage.emit || out_free);

    always_comb begin
        red_pass = (i_stage.red > RED_MIN)
            && ({4'd0, i_stage.red} * 12'd7 > {4'd0, i_stage.green} * 12'd10)
            && ({4'd0, i_stage.red} * 12'd7 > {4'd0, i_stage.blue} * 12'd10);
        green_pass = (i_stage.green > GREEN_MIN)
            && ({5'd0, i_stage.green} * 13'd17 > {5'd0, i_stage.red} * 13'd20)
            && ({5'd0, i_stage.green} * 13'd17 > {5'd0, i_stage.blue} * 13'd20);
        blue_pass = (i_stage.blue > BLUE_MIN)
            && ({2'd0, i_stage.blue} * 10'd3 > {2'd0, i_stage.red} * 10'd4)
            && ({2'd0, i_stage.blue} * 10'd3 > {2'd0, i_stage.green} * 10'd4);
    end

    // an entry past the written prefix is read as black, whatever the store holds
    assign old_lvl = i_stage.fresh ? 8'd0 : i_rdata;
    assign sum_lvl = {1'b0, old_lvl} + {1'b0, i_cfg.accum_step};
    assign new_lvl = (i_cfg.pattern_mode && !sum_lvl[8]) ? sum_lvl[7:0] : old_lvl;
    assign is_edge = (i_stage.diff_red > i_cfg.edge_threshold)
        && (i_stage.diff_green > i_cfg.edge_threshold)
        && (i_stage.diff_blue > i_cfg.edge_threshold);

    assign o_wr_en   = o_stage_adv && i_stage.access;
    assign o_wr_addr = i_stage_idx;
    assign o_wr_data = is_edge ? new_lvl : 8'd0;

    always_comb begin
        n_out = '0;
        if (!i_cfg.trace_target) begin
            case (t_color'(i_cfg.color_select))
                COLOR_RED: begin
                    n_out.red_out = red_pass ? FULL_ON : 8'd0;
                    n_out.hit     = red_pass;
                end
                COLOR_GREEN: begin
                    n_out.green_out = green_pass ? FULL_ON : 8'd0;
                    n_out.hit       = green_pass;
                end
                COLOR_BLUE: begin
                    n_out.blue_out = blue_pass ? FULL_ON : 8'd0;
                    n_out.hit      = blue_pass;
                end
                default: ;
            endcase
        end else if (is_edge) begin
            n_out.hit         = 1'b1;
            n_out.accum_level = new_lvl;
            if (i_cfg.pattern_mode) begin
                n_out.red_out   = new_lvl;
                n_out.green_out = new_lvl;
                n_out.blue_out  = new_lvl;
            end else begin
                n_out.red_out   = FULL_ON;
                n_out.green_out = FULL_ON;
                n_out.blue_out  = FULL_ON;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (o_stage_adv && i_stage.emit) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_stage_adv && i_stage.emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    a_out_from_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(i_stage_vld))
        else $error("result word appeared without a staged pixel");

    a_miss_is_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out.hit) |->
            (r_out.red_out == 8'd0 && r_out.green_out == 8'd0 && r_out.blue_out == 8'd0))
        else $error("missed pixel is not black");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_out_stall && i_stage_vld && i_stage.emit) |-> !o_stage_adv)
        else $error("staged pixel advanced onto a held result word");
`endif

endmodule

// ----- rtl/core/pixel_color_and_edge_tracer.sv -----
// top level of the pixel color and edge tracer
//
// input channel: one pixel word per accepted cycle (i_in_valid high, o_in_stall low).
// output channel: one result word per pixel, except a frame start pixel in trace
// mode, which only loads the previous pixel and rewinds the store position.
// configuration: apb registers; the user must write them only while the block is idle; the block has no check.
// pipeline: the accepting edge loads the input register and the edge store read data,
// and the pixel moves on into the result register once that register is free.
// throughput: one pixel per cycle while the receiver does not stall, set by the single
// read port and single write port of the edge store, used once per pixel each.
// when the receiver stalls, the result register holds its word and the input
// register can still take one more pixel; beyond that o_in_stall goes high.
// reset: registers take their defaults, the previous pixel and store position
// clear, and a fill count makes every store entry read black until it is first
// written, so there is no clearing pass and pixels are taken right after reset.
module pixel_color_and_edge_tracer
    import ptrc_pkg::*;
#(
    parameter int unsigned FRAME_PIXELS = FRAME_PIXELS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_pix_in           i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_pix_out          o_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int unsigned AW = $clog2(FRAME_PIXELS);

    t_cfg          cfg;
    logic          stage_vld;
    t_stage        stage;
    logic [AW-1:0] stage_idx;
    logic          stage_adv;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rdata;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;

    ptrc_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ptrc_input_stage #(
        .FRAME_PIXELS (FRAME_PIXELS),
        .AW           (AW)
    ) u_input_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_cfg       (cfg),
        .i_stage_adv (stage_adv),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .o_stage_vld (stage_vld),
        .o_stage     (stage),
        .o_stage_idx (stage_idx)
    );

    ptrc_ram #(
        .DEPTH (FRAME_PIXELS),
        .AW    (AW)
    ) u_edge_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rdata)
    );

    ptrc_result_stage #(
        .FRAME_PIXELS (FRAME_PIXELS),
        .AW           (AW)
    ) u_result_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_stage_vld (stage_vld),
        .i_stage     (stage),
        .i_stage_idx (stage_idx),
        .i_rdata     (rdata),
        .o_stage_adv (stage_adv),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- dv/ptrc_trace_checker.sv -----
// watches the pixel and result channels, predicts every result word and compares it
module ptrc_trace_checker
    import ptrc_pkg::*;
#(
    parameter int unsigned FRAME_PIXELS = FRAME_PIXELS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  t_pix_in           i_in_data,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  t_pix_out          i_out_data,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic              i_pready,
    input  logic [APB_AW-1:0] i_paddr,
    input  logic [APB_DW-1:0] i_pwdata,
    output int                o_fail_count,
    output int                o_words_due
);

    // register copy
    logic       trace_target;
    t_color     color_sel;
    logic       pattern_mode;
    logic [7:0] edge_threshold;
    logic [7:0] accum_step;

    // pixel history and edge level store
    logic [7:0]  prev_red;
    logic [7:0]  prev_green;
    logic [7:0]  prev_blue;
    int unsigned store_pos;
    logic [7:0]  level_store [FRAME_PIXELS];

    t_pix_out traced_words [$];
    t_pix_out traced;
    t_pix_out wanted;
    int       words_seen;

    initial o_fail_count = 0;
    initial o_words_due = 0;

    task automatic report(string msg);
        $display("[%0t] mismatch at result word %0d: %s", $realtime, words_seen, msg);
        o_fail_count++;
    endtask

    task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
        if (got !== want)
            report($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    task automatic write_reg(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
        case (t_reg_idx'(addr[4:2]))
            REG_TRACE_TARGET:   trace_target = data[0];
            REG_COLOR_SELECT:   color_sel = t_color'(data[1:0]);
            REG_PATTERN_MODE:   pattern_mode = data[0];
            REG_EDGE_THRESHOLD: edge_threshold = data[7:0];
            REG_ACCUM_STEP:     accum_step = data[7:0];
            default: ;
        endcase
    endtask

    // returns 1 when the pixel yields a result word
    function automatic bit trace_pixel(input t_pix_in px, output t_pix_out res);
        int         r;
        int         g;
        int         b;
        logic [7:0] dr;
        logic [7:0] dg;
        logic [7:0] db;
        logic [7:0] lvl;
        bit         pass;
        bit         edge_hit;
        r = px.red_in;
        g = px.green_in;
        b = px.blue_in;
        dr = px.red_in - prev_red;
        dg = px.green_in - prev_green;
        db = px.blue_in - prev_blue;
        prev_red = px.red_in;
        prev_green = px.green_in;
        prev_blue = px.blue_in;
        res = '0;
        pass = 1'b0;

        if (!trace_target) begin
            if (px.frame_start)
                store_pos = 0;
            case (color_sel)
                COLOR_RED: begin
                    pass = r > RED_MIN && 7 * r > 10 * g && 7 * r > 10 * b;
                    res.red_out = pass ? FULL_ON : 8'd0;
                end
                COLOR_GREEN: begin
                    pass = g > GREEN_MIN && 17 * g > 20 * r && 17 * g > 20 * b;
                    res.green_out = pass ? FULL_ON : 8'd0;
                end
                COLOR_BLUE: begin
                    pass = b > BLUE_MIN && 3 * b > 4 * r && 3 * b > 4 * g;
                    res.blue_out = pass ? FULL_ON : 8'd0;
                end
                default: ;
            endcase
            res.hit = pass;
            return 1'b1;
        end

        // first pixel of a frame only loads the previous pixel and rewinds the store position
        if (px.frame_start) begin
            store_pos = 0;
            return 1'b0;
        end

        if (store_pos >= FRAME_PIXELS)
            store_pos = 0;
        edge_hit = dr > edge_threshold && dg > edge_threshold && db > edge_threshold;
        lvl = level_store[store_pos];
        if (!edge_hit) begin
            level_store[store_pos] = '0;
        end else if (!pattern_mode) begin
            res = '{red_out: FULL_ON, green_out: FULL_ON, blue_out: FULL_ON,
                    accum_level: lvl, hit: 1'b1};
        end else begin
            // saturate below 256
            if (int'(lvl) < 256 - int'(accum_step)) begin
                lvl = lvl + accum_step;
                level_store[store_pos] = lvl;
            end
            res = '{red_out: lvl, green_out: lvl, blue_out: lvl, accum_level: lvl, hit: 1'b1};
        end
        store_pos = (store_pos + 1 >= FRAME_PIXELS) ? 0 : store_pos + 1;
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            trace_target = 1'b0;
            color_sel = COLOR_RED;
            pattern_mode = 1'b0;
            edge_threshold = EDGE_THRESHOLD_RST;
            accum_step = ACCUM_STEP_RST;
            prev_red = '0;
            prev_green = '0;
            prev_blue = '0;
            store_pos = 0;
            foreach (level_store[i])
                level_store[i] = '0;
            traced_words.delete();
            words_seen = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready)
                write_reg(i_paddr, i_pwdata);
            if (i_out_valid && !i_out_stall) begin
                if (traced_words.size() == 0) begin
                    report("result word with nothing expected");
                end else begin
                    wanted = traced_words.pop_front();
                    check_field("red_out", i_out_data.red_out, wanted.red_out);
                    check_field("green_out", i_out_data.green_out, wanted.green_out);
                    check_field("blue_out", i_out_data.blue_out, wanted.blue_out);
                    check_field("accum_level", i_out_data.accum_level, wanted.accum_level);
                    check_field("hit", 8'(i_out_data.hit), 8'(wanted.hit));
                end
                words_seen++;
            end
            if (i_in_valid && !i_in_stall) begin
                if (trace_pixel(i_in_data, traced))
                    traced_words.push_back(traced);
            end
        end
        o_words_due = traced_words.size();
    end

endmodule

// ----- dv/pixel_color_and_edge_tracer_tb.sv -----
// testbench top: pixel stimulus, register setup and verdict for the tracer
module pixel_color_and_edge_tracer_tb;
    import ptrc_pkg::*;

    localparam int unsigned TB_FRAME_PIXELS = 1024;
    localparam logic [APB_AW-1:0] UNUSED_REG_ADDR = 5'd20;

    logic              i_clk;
    logic              i_rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    t_pix_in           in_word = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    t_pix_out          out_word;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    int fail_count;
    int words_due;
    int idle_pct = 0;
    int stall_pct = 0;

    // stimulus side view of the block
    t_pix_in    last_px = '0;
    logic [7:0] thr_now = EDGE_THRESHOLD_RST;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(negedge i_clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    pixel_color_and_edge_tracer #(
        .FRAME_PIXELS(TB_FRAME_PIXELS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_word),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_word),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    ptrc_trace_checker #(
        .FRAME_PIXELS(TB_FRAME_PIXELS)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_word),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_word),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_pready    (pready),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .o_fail_count(fail_count),
        .o_words_due (words_due)
    );

    function automatic t_pix_in pix(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fs);
        t_pix_in p;
        p.red_in = r;
        p.green_in = g;
        p.blue_in = b;
        p.frame_start = fs;
        return p;
    endfunction

    // edge_pct: chance of a pixel far enough from the last one on all channels
    // skew_pct: chance of one dominant channel, to hit the color tests
    function automatic t_pix_in make_pixel(int edge_pct, int fs_pct, int skew_pct);
        t_pix_in p;
        int      k;
        p.red_in = 8'($urandom());
        p.green_in = 8'($urandom());
        p.blue_in = 8'($urandom());
        if ($urandom_range(99) < edge_pct && thr_now < 8'd255) begin
            p.red_in = last_px.red_in + 8'($urandom_range(255, thr_now + 1));
            p.green_in = last_px.green_in + 8'($urandom_range(255, thr_now + 1));
            p.blue_in = last_px.blue_in + 8'($urandom_range(255, thr_now + 1));
        end else if ($urandom_range(99) < skew_pct) begin
            k = $urandom_range(2);
            p.red_in = (k == 0) ? 8'($urandom_range(255, 90)) : 8'($urandom_range(110));
            p.green_in = (k == 1) ? 8'($urandom_range(255, 55)) : 8'($urandom_range(110));
            p.blue_in = (k == 2) ? 8'($urandom_range(255, 90)) : 8'($urandom_range(110));
        end
        p.frame_start = ($urandom_range(99) < fs_pct);
        return p;
    endfunction

    task automatic send_pixel(t_pix_in px);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_word <= px;
        do @(posedge i_clk); while (in_stall);
        last_px = px;
    endtask

    // sender holds off until every result word is back and the pipe is empty
    task automatic wait_idle();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (words_due != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic apb_write(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // upper bits carry junk so that width masking is exercised
    task automatic configure(logic target, t_color color, logic mode,
                             logic [7:0] thr, logic [7:0] step);
        logic [31:0] junk;
        junk = $urandom();
        apb_write({REG_TRACE_TARGET, 2'b00}, {junk[31:1], target});
        apb_write({REG_COLOR_SELECT, 2'b00}, {junk[31:2], color});
        apb_write({REG_PATTERN_MODE, 2'b00}, {junk[30:0], mode});
        apb_write({REG_EDGE_THRESHOLD, 2'b00}, {junk[31:8], thr});
        apb_write({REG_ACCUM_STEP, 2'b00}, {junk[23:0], step});
        thr_now = thr;
    endtask

    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int n_items;
        int edge_pct;
        int fs_pct;
        int skew_pct;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // color tests at reset settings, red selected
        send_pixel(pix(8'd0, 8'd0, 8'd0, 1'b0));
        send_pixel(pix(8'd255, 8'd255, 8'd255, 1'b0));
        send_pixel(pix(8'd255, 8'd0, 8'd0, 1'b0));
        send_pixel(pix(8'd101, 8'd70, 8'd70, 1'b0));
        send_pixel(pix(8'd100, 8'd0, 8'd0, 1'b0));
        send_pixel(pix(8'd101, 8'd71, 8'd0, 1'b1));
        wait_idle();
        configure(1'b0, COLOR_GREEN, 1'b0, 8'd80, 8'd16);
        send_pixel(pix(8'd0, 8'd255, 8'd0, 1'b0));
        send_pixel(pix(8'd51, 8'd61, 8'd51, 1'b0));
        send_pixel(pix(8'd0, 8'd60, 8'd0, 1'b0));
        wait_idle();
        configure(1'b0, COLOR_BLUE, 1'b0, 8'd80, 8'd16);
        send_pixel(pix(8'd0, 8'd0, 8'd255, 1'b0));
        send_pixel(pix(8'd75, 8'd75, 8'd101, 1'b0));
        send_pixel(pix(8'd76, 8'd0, 8'd101, 1'b0));
        wait_idle();
        // unused selector gives black
        configure(1'b0, COLOR_NONE, 1'b0, 8'd80, 8'd16);
        apb_write(UNUSED_REG_ADDR, $urandom());
        send_pixel(pix(8'd255, 8'd0, 8'd0, 1'b0));
        send_pixel(pix(8'd0, 8'd0, 8'd255, 1'b0));
        wait_idle();
        // plain edge map, difference just above and at the threshold
        configure(1'b1, COLOR_RED, 1'b0, 8'd80, 8'd16);
        send_pixel(pix(8'd0, 8'd0, 8'd0, 1'b1));
        send_pixel(pix(8'd81, 8'd81, 8'd81, 1'b0));
        send_pixel(pix(8'd161, 8'd161, 8'd161, 1'b0));
        send_pixel(pix(8'd0, 8'd0, 8'd0, 1'b0));
        wait_idle();
        // accumulate with a large step saturates on the second visit
        configure(1'b1, COLOR_RED, 1'b1, 8'd0, 8'd200);
        send_pixel(pix(8'd0, 8'd0, 8'd0, 1'b1));
        send_pixel(pix(8'd1, 8'd1, 8'd1, 1'b0));
        send_pixel(pix(8'd0, 8'd0, 8'd0, 1'b1));
        send_pixel(pix(8'd1, 8'd1, 8'd1, 1'b0));
        wait_idle();
        // zero step leaves the stored level alone
        configure(1'b1, COLOR_RED, 1'b1, 8'd0, 8'd0);
        send_pixel(pix(8'd0, 8'd0, 8'd0, 1'b1));
        send_pixel(pix(8'd255, 8'd255, 8'd255, 1'b0));
        send_pixel(pix(8'd255, 8'd255, 8'd255, 1'b0));

        for (int ph = 0; ph < 8; ph++) begin
            wait_idle();
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 69; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 69; end
                default: begin idle_pct = 13; stall_pct = 13; end
            endcase
            case (ph)
                0, 3: configure(1'b0, t_color'($urandom_range(3)), 1'($urandom()),
                                8'($urandom()), 8'($urandom()));
                1: configure(1'b1, COLOR_RED, 1'b0, 8'($urandom()), 8'($urandom()));
                2: configure(1'b1, COLOR_GREEN, 1'b1, 8'd80, 8'd16);
                4: configure(1'b1, COLOR_BLUE, 1'b1, 8'd0, 8'd255);
                5: configure(1'b1, COLOR_NONE, 1'b0, 8'd255, 8'd1);
                6: configure(1'b1, COLOR_RED, 1'b1, 8'($urandom_range(120)), 8'd1);
                default: configure(1'b0, COLOR_NONE, 1'b1, 8'($urandom()), 8'($urandom()));
            endcase
            if (ph == 0 || ph == 3 || ph == 7) begin
                edge_pct = 5;
                fs_pct = 5;
                skew_pct = 40;
            end else begin
                edge_pct = 85;
                fs_pct = 8;
                skew_pct = 0;
            end
            n_items = 0;
            while (n_items < 115) begin
                if (ph == 2 && n_items == 55)
                    wait_idle();
                send_pixel(make_pixel(edge_pct, fs_pct, skew_pct));
                n_items++;
            end
        end

        wait_idle();
        repeat (10) @(negedge i_clk);
        if (fail_count == 0 && words_due == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
